// ----- hw/rtl/bas_pkg.sv -----
package bas_pkg;

    localparam int LN_W    = 21;
    localparam int ROOT_W  = 19;
    localparam int BONUS_W = 19;
    localparam int UCB_W   = 22;
    localparam int LN2_Q16 = 45426;

    localparam logic signed [UCB_W-1:0] START_MAX = -22'sd2560;
    localparam logic [15:0] REF_INIT = 16'd384;

    localparam logic [1:0] OP_SELECT  = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] MODE_EPS  = 2'd0;
    localparam logic [1:0] MODE_OPT  = 2'd1;
    localparam logic [1:0] MODE_RC   = 2'd2;
    localparam logic [1:0] MODE_UCB  = 2'd3;

    localparam logic [2:0] REG_POLICY  = 3'd0;
    localparam logic [2:0] REG_ARMS    = 3'd1;
    localparam logic [2:0] REG_EPS     = 3'd2;
    localparam logic [2:0] REG_INIT    = 3'd3;
    localparam logic [2:0] REG_ALPHA   = 3'd4;
    localparam logic [2:0] REG_BETA    = 3'd5;
    localparam logic [2:0] REG_WEIGHT  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LN_WAIT,
        ST_RD,
        ST_EVAL,
        ST_BONUS_WAIT,
        ST_UPD_RD,
        ST_UPD_MOD,
        ST_UPD_WR2,
        ST_DONE
    } bas_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_NORM,
        U_MUL,
        U_SQ,
        U_LN,
        U_DIV,
        U_SQRT,
        U_MUL_C
    } ucb_state_t;

    typedef struct packed {
        logic start_ln;
        logic start_bonus;
    } ucb_ctl_t;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] res;
        if (v > 19'sd32767)
        begin
            res = 16'h7fff;
        end
        else if (v < -19'sd32768)
        begin
            res = 16'h8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/bas_interfaces.sv -----
interface bas_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] uniform_draw;
    logic [3:0]  random_arm;
    logic [3:0]  pulled_arm;
    logic [15:0] reward_value;

    modport source (output valid, operation, uniform_draw, random_arm, pulled_arm,
                    reward_value, input ready);
    modport sink (input valid, operation, uniform_draw, random_arm, pulled_arm,
                  reward_value, output ready);
endinterface

interface bas_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] chosen_arm;
    logic       explored;
    logic [3:0] leading_arm;

    modport source (output valid, chosen_arm, explored, leading_arm, input ready);
    modport sink (input valid, chosen_arm, explored, leading_arm, output ready);
endinterface

// ----- hw/rtl/bas_mem.sv -----
module bas_mem #(
    parameter int AW = 4,
    parameter int DW = 56
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- hw/rtl/bas_ucb.sv -----
module bas_ucb #(
    parameter int CB = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bas_pkg::ucb_ctl_t             ctl,
    input  logic [CB-1:0]                 total,
    input  logic [CB-1:0]                 count,
    input  logic [15:0]                   weight,
    output logic                          done,
    output logic [bas_pkg::BONUS_W-1:0]   bonus
);
    import bas_pkg::*;

    ucb_state_t          st_reg, st_next;
    logic [CB-1:0]       m_reg, m_next;
    logic [4:0]          n_reg, n_next;
    logic [30:0]         y_reg, y_next;
    logic [61:0]         prod_reg, prod_next;
    logic [15:0]         frac_reg, frac_next;
    logic [4:0]          it_reg, it_next;
    logic [LN_W-1:0]     ln_reg, ln_next;
    logic [LN_W-1:0]     dvd_reg, dvd_next;
    logic [CB-1:0]       rem_reg, rem_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic [37:0]         v_reg, v_next;
    logic [19:0]         sr_reg, sr_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [BONUS_W-1:0]  bonus_reg, bonus_next;
    logic                done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        n_reg     <= n_next;
        y_reg     <= y_next;
        prod_reg  <= prod_next;
        frac_reg  <= frac_next;
        it_reg    <= it_next;
        ln_reg    <= ln_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        v_reg     <= v_next;
        sr_reg    <= sr_next;
        root_reg  <= root_next;
        bonus_reg <= bonus_next;
    end

    always_comb
    begin
        logic [CB+30:0]    ext;
        logic [31:0]       sq;
        logic [LN_W-1:0]   lg;
        logic [LN_W+15:0]  lnp;
        logic [CB:0]       remsh;
        logic [21:0]       srsh;
        logic [21:0]       trial;
        logic [34:0]       cp;
        logic              qbit;

        st_next    = st_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        y_next     = y_reg;
        prod_next  = prod_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        ln_next    = ln_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        sr_next    = sr_reg;
        root_next  = root_reg;
        bonus_next = bonus_reg;
        done_next  = 1'b0;

        ext   = {m_reg, 31'b0};
        sq    = prod_reg[61:30];
        lg    = {n_reg, frac_reg};
        lnp   = lg * 16'(LN2_Q16);
        remsh = {rem_reg, dvd_reg[LN_W-1]};
        qbit  = (remsh >= {1'b0, cnt_reg});
        srsh  = {sr_reg, v_reg[37:36]};
        trial = {1'b0, root_reg, 2'b01};
        cp    = weight * root_reg;

        unique case (st_reg)
            U_IDLE:
            begin
                if (ctl.start_ln)
                begin
                    if (total == '0)
                    begin
                        ln_next   = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        m_next  = total;
                        n_next  = 5'(CB - 1);
                        st_next = U_NORM;
                    end
                end
                else if (ctl.start_bonus)
                begin
                    dvd_next = ln_reg;
                    rem_next = '0;
                    cnt_next = count;
                    it_next  = '0;
                    st_next  = U_DIV;
                end
            end
            U_NORM:
            begin
                if (m_reg[CB-1])
                begin
                    y_next    = ext[CB+30 -: 31];
                    frac_next = '0;
                    it_next   = '0;
                    st_next   = U_MUL;
                end
                else
                begin
                    m_next = {m_reg[CB-2:0], 1'b0};
                    n_next = n_reg - 5'd1;
                end
            end
            U_MUL:
            begin
                prod_next = y_reg * y_reg;
                st_next   = U_SQ;
            end
            U_SQ:
            begin
                if (sq[31])
                begin
                    y_next    = sq[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    y_next    = sq[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                if (it_reg == 5'd15)
                begin
                    st_next = U_LN;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                    st_next = U_MUL;
                end
            end
            U_LN:
            begin
                ln_next   = lnp[LN_W+15:16];
                done_next = 1'b1;
                st_next   = U_IDLE;
            end
            U_DIV:
            begin
                if (qbit)
                begin
                    rem_next = CB'(remsh - {1'b0, cnt_reg});
                end
                else
                begin
                    rem_next = remsh[CB-1:0];
                end
                dvd_next = {dvd_reg[LN_W-2:0], qbit};
                if (it_reg == 5'(LN_W - 1))
                begin
                    v_next    = {1'b0, dvd_reg[LN_W-2:0], qbit, 16'b0};
                    sr_next   = '0;
                    root_next = '0;
                    it_next   = '0;
                    st_next   = U_SQRT;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                end
            end
            U_SQRT:
            begin
                if (srsh >= trial)
                begin
                    sr_next   = 20'(srsh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sr_next   = srsh[19:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                v_next = {v_reg[35:0], 2'b00};
                if (it_reg == 5'(ROOT_W - 1))
                begin
                    st_next = U_MUL_C;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                end
            end
            U_MUL_C:
            begin
                bonus_next = cp[34:16];
                done_next  = 1'b1;
                st_next    = U_IDLE;
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    assign done  = done_reg;
    assign bonus = bonus_reg;
endmodule

// ----- hw/rtl/bandit_arm_selector_core.sv -----
// Channel | Dir | Fields                                                   | Transaction
// req     | in  | operation, uniform_draw, random_arm, pulled_arm, reward  | valid & ready
// rsp     | out | chosen_arm, explored, leading_arm                        | valid & ready
// wr_*    | in  | wr_index (register), wr_data                             | wr_en
// One transaction in flight; a result waits in the output register while the next is taken.
// Select, modes 0-2: a read and an evaluate step per arm; no scan when mode 0 explores.
// Update: read, modify and write the arm, and in mode 2 also the leading arm's preference;
// an arm not below K is skipped. Restart clears all MAX_ARMS entries of the arm memory.
// Select, mode 3: log unit, then per arm a read and divide, root and multiply in the UCB unit;
// an arm with no pulls ends the scan. After reset a clearing pass over all entries runs, req.ready low.
module bandit_arm_selector_core #(
    parameter int MAX_ARMS   = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    bas_req_if.sink     req,
    bas_rsp_if.source   rsp,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data
);
    import bas_pkg::*;

    localparam int AW = $clog2(MAX_ARMS);
    localparam int KW = $clog2(MAX_ARMS + 1);
    localparam int CB = COUNT_BITS;
    localparam int DW = 32 + CB;
    localparam int MW = (KW > 5) ? KW + 1 : 6;

    bas_state_t          state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [15:0]         u_reg, u_next;
    logic [3:0]          rarm_reg, rarm_next;
    logic [15:0]         r_reg, r_next;
    logic [AW-1:0]       best_reg, best_next;
    logic signed [UCB_W-1:0] mx_reg, mx_next;
    logic [15:0]         est_hold_reg, est_hold_next;
    logic [CB-1:0]       total_reg, total_next;
    logic [15:0]         ref_reg, ref_next;
    logic [3:0]          chosen_reg, chosen_next;
    logic                explored_reg, explored_next;
    logic [15:0]         sweep_reg, sweep_next;
    logic                pend_reg, pend_next;
    logic [DW-1:0]       wr2_reg, wr2_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_chosen_reg, out_chosen_next;
    logic                out_explored_reg, out_explored_next;
    logic [3:0]          out_leading_reg, out_leading_next;

    logic [1:0]          mode_reg;
    logic [4:0]          arms_reg;
    logic [15:0]         eps_reg;
    logic [15:0]         init_reg;
    logic [15:0]         alpha_reg;
    logic [15:0]         beta_reg;
    logic [15:0]         weight_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [DW-1:0]       rdata_a;
    logic [DW-1:0]       rdata_b;

    ucb_ctl_t            ucb_ctl;
    logic                ucb_done;
    logic [BONUS_W-1:0]  ucb_bonus;

    logic [KW-1:0]       k_now;
    logic [3:0]          rarm_now;

    function automatic logic [3:0] arm4(input logic [AW-1:0] a);
        logic [AW+3:0] t;
        t = {4'b0, a};
        return t[3:0];
    endfunction

    function automatic logic [AW-1:0] to_idx(input logic [3:0] a);
        logic [AW+3:0] t;
        t = {{AW{1'b0}}, a};
        return t[AW-1:0];
    endfunction

    bas_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (idx_reg),
        .raddr_b (best_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bas_ucb #(.CB(CB)) u_ucb (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ucb_ctl),
        .total  (total_reg),
        .count  (rdata_a[CB+15:16]),
        .weight (weight_reg),
        .done   (ucb_done),
        .bonus  (ucb_bonus)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_EPS;
            arms_reg   <= 5'd16;
            eps_reg    <= 16'd6554;
            init_reg   <= 16'd0;
            alpha_reg  <= 16'd6554;
            beta_reg   <= 16'd6554;
            weight_reg <= 16'd512;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_POLICY: mode_reg   <= wr_data[1:0];
                REG_ARMS:   arms_reg   <= wr_data[4:0];
                REG_EPS:    eps_reg    <= wr_data;
                REG_INIT:   init_reg   <= wr_data;
                REG_ALPHA:  alpha_reg  <= wr_data;
                REG_BETA:   beta_reg   <= wr_data;
                REG_WEIGHT: weight_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        logic [MW-1:0] rm;
        if (arms_reg == 5'd0)
        begin
            k_now = KW'(1);
        end
        else if (32'(arms_reg) > MAX_ARMS)
        begin
            k_now = KW'(MAX_ARMS);
        end
        else
        begin
            k_now = KW'(arms_reg);
        end
        rm = '0;
        for (int i = 3; i >= 0; i--)
        begin
            rm = {rm[MW-2:0], req.random_arm[i]};
            if (rm >= MW'(k_now))
            begin
                rm = rm - MW'(k_now);
            end
        end
        rarm_now = rm[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            best_reg      <= '0;
            total_reg     <= '0;
            ref_reg       <= REF_INIT;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            best_reg      <= best_next;
            total_reg     <= total_next;
            ref_reg       <= ref_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg            <= k_next;
        u_reg            <= u_next;
        rarm_reg         <= rarm_next;
        r_reg            <= r_next;
        mx_reg           <= mx_next;
        est_hold_reg     <= est_hold_next;
        chosen_reg       <= chosen_next;
        explored_reg     <= explored_next;
        wr2_reg          <= wr2_next;
        out_chosen_reg   <= out_chosen_next;
        out_explored_reg <= out_explored_next;
        out_leading_reg  <= out_leading_next;
    end

    always_comb
    begin
        logic [15:0]             a_est, a_pref, b_est, b_pref, est_new, pref_new, rf_new;
        logic [CB-1:0]           a_cnt, b_cnt, cnt_new;
        logic [16:0]             sum17, d17;
        logic signed [33:0]      pb, pa;
        logic [15:0]             hold_est;
        logic signed [UCB_W-1:0] cand, m_new;
        logic [AW-1:0]           b_new;
        logic                    adv, last;
        logic signed [25:0]      lhs, rhs;

        state_next        = state_reg;
        idx_next          = idx_reg;
        k_next            = k_reg;
        u_next            = u_reg;
        rarm_next         = rarm_reg;
        r_next            = r_reg;
        best_next         = best_reg;
        mx_next           = mx_reg;
        est_hold_next     = est_hold_reg;
        total_next        = total_reg;
        ref_next          = ref_reg;
        chosen_next       = chosen_reg;
        explored_next     = explored_reg;
        sweep_next        = sweep_reg;
        pend_next         = pend_reg;
        wr2_next          = wr2_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_chosen_next   = out_chosen_reg;
        out_explored_next = out_explored_reg;
        out_leading_next  = out_leading_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = rdata_a;
        ucb_ctl           = '0;

        a_est    = rdata_a[DW-1 -: 16];
        a_cnt    = rdata_a[CB+15:16];
        a_pref   = rdata_a[15:0];
        b_est    = rdata_b[DW-1 -: 16];
        b_cnt    = rdata_b[CB+15:16];
        b_pref   = rdata_b[15:0];
        sum17    = {a_est[15], a_est} + {r_reg[15], r_reg};
        est_new  = (a_est == 16'd0) ? r_reg : sum17[16:1];
        cnt_new  = (&a_cnt) ? a_cnt : a_cnt + CB'(1);
        d17      = {r_reg[15], r_reg} - {ref_reg[15], ref_reg};
        pb       = $signed({1'b0, beta_reg}) * $signed(d17);
        pa       = $signed({1'b0, alpha_reg}) * $signed(d17);
        pref_new = sat16($signed({{3{b_pref[15]}}, b_pref}) + $signed({pb[33], pb[33:16]}));
        rf_new   = sat16($signed({{3{ref_reg[15]}}, ref_reg}) + $signed({pa[33], pa[33:16]}));

        hold_est = (state_reg == ST_EVAL) ? a_est : est_hold_reg;
        cand     = (state_reg == ST_EVAL)
                   ? ((mode_reg == MODE_RC) ? $signed({{6{a_pref[15]}}, a_pref})
                                            : $signed({{6{a_est[15]}}, a_est}))
                   : $signed({{6{hold_est[15]}}, hold_est}) + $signed({3'b0, ucb_bonus});
        m_new    = mx_reg;
        b_new    = best_reg;
        adv      = 1'b0;
        last     = (32'(idx_reg) + 1 == 32'(k_reg));
        lhs      = $signed({10'b0, u_reg});
        rhs      = $signed({m_new[15], m_new[15], m_new[15:0], 8'b0});

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {sweep_reg, {CB{1'b0}}, 16'b0};
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == AW'(MAX_ARMS - 1))
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    u_next        = req.uniform_draw;
                    rarm_next     = rarm_now;
                    r_next        = req.reward_value;
                    k_next        = k_now;
                    chosen_next   = '0;
                    explored_next = 1'b0;
                    idx_next      = '0;
                    mx_next       = START_MAX;
                    case (req.operation)
                        OP_SELECT:
                        begin
                            if (mode_reg == MODE_EPS && req.uniform_draw <= eps_reg)
                            begin
                                chosen_next   = rarm_now;
                                explored_next = 1'b1;
                                state_next    = ST_DONE;
                            end
                            else if (mode_reg == MODE_UCB)
                            begin
                                ucb_ctl.start_ln = 1'b1;
                                state_next       = ST_LN_WAIT;
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (32'(req.pulled_arm) < 32'(k_now))
                            begin
                                idx_next   = to_idx(req.pulled_arm);
                                state_next = ST_UPD_RD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_RESTART:
                        begin
                            total_next = '0;
                            best_next  = '0;
                            ref_next   = REF_INIT;
                            sweep_next = init_reg;
                            pend_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LN_WAIT:
            begin
                if (ucb_done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (mode_reg == MODE_UCB)
                begin
                    if (a_cnt == '0)
                    begin
                        chosen_next = arm4(idx_reg);
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        est_hold_next       = a_est;
                        ucb_ctl.start_bonus = 1'b1;
                        state_next          = ST_BONUS_WAIT;
                    end
                end
                else
                begin
                    adv = 1'b1;
                    if (cand > mx_reg || (mode_reg == MODE_RC && idx_reg == '0))
                    begin
                        m_new = cand;
                        b_new = idx_reg;
                    end
                end
            end
            ST_BONUS_WAIT:
            begin
                if (ucb_done)
                begin
                    adv = 1'b1;
                    if (cand > mx_reg)
                    begin
                        m_new = cand;
                        b_new = idx_reg;
                    end
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_MOD;
            end
            ST_UPD_MOD:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {est_new, cnt_new, a_pref};
                total_next = (&total_reg) ? total_reg : total_reg + CB'(1);
                state_next = ST_DONE;
                if (mode_reg == MODE_EPS || mode_reg == MODE_OPT)
                begin
                    if (best_reg != idx_reg && $signed(est_new) > $signed(b_est))
                    begin
                        best_next = idx_reg;
                    end
                end
                else if (mode_reg == MODE_RC)
                begin
                    ref_next = rf_new;
                    if (best_reg == idx_reg)
                    begin
                        mem_wdata = {est_new, cnt_new, pref_new};
                    end
                    else
                    begin
                        wr2_next   = {b_est, b_cnt, pref_new};
                        state_next = ST_UPD_WR2;
                    end
                end
            end
            ST_UPD_WR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_reg;
                mem_wdata  = wr2_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_chosen_next   = chosen_reg;
                    out_explored_next = explored_reg;
                    out_leading_next  = arm4(best_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rhs = $signed({m_new[15], m_new[15], m_new[15:0], 8'b0});
        if (adv)
        begin
            mx_next   = m_new;
            best_next = b_new;
            if (last)
            begin
                state_next = ST_DONE;
                if (mode_reg == MODE_RC && lhs <= rhs)
                begin
                    chosen_next   = rarm_reg;
                    explored_next = 1'b1;
                end
                else
                begin
                    chosen_next = arm4(b_new);
                end
            end
            else
            begin
                idx_next   = idx_reg + AW'(1);
                state_next = ST_RD;
            end
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.chosen_arm  = out_chosen_reg;
    assign rsp.explored    = out_explored_reg;
    assign rsp.leading_arm = out_leading_reg;
endmodule

// ----- tb/bandit_arm_selector_core_tb.sv -----
module bandit_arm_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bas_pkg::*;

    localparam int        NARMS        = 16;
    localparam int        CNT_BITS     = 24;
    localparam int        CYCLE_LIMIT  = 4000000;
    localparam int        PHASES       = 10;
    localparam int        PHASE_ITEMS  = 90;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic [3:0] chosen_arm;
        logic       explored;
        logic [3:0] leading_arm;
    } outcome_t;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] u;
        logic [3:0]  rnd;
        logic [3:0]  arm;
        logic [15:0] r;
        bit          typed;
        outcome_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    bas_req_if req ();
    bas_rsp_if rsp ();

    bandit_arm_selector_core #(.MAX_ARMS(NARMS), .COUNT_BITS(CNT_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // shadow configuration
    logic [1:0]  cfg_mode;
    logic [4:0]  cfg_arms;
    int unsigned cfg_eps;
    int          cfg_init;
    int unsigned cfg_alpha;
    int unsigned cfg_beta;
    int unsigned cfg_weight;

    // shadow arm state
    int          est [NARMS];
    int unsigned pulls [NARMS];
    int          pref [NARMS];
    int unsigned total_pulls;
    int unsigned leader;
    int          ref_reward;

    outcome_t pending_outcomes[$];
    int       failures;
    int       cycles;
    int       burst_left;
    bit       sender_low;
    int unsigned stall_cnt;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned active_arms();
        if (cfg_arms < 1)
        begin
            return 1;
        end
        if (cfg_arms > NARMS)
        begin
            return NARMS;
        end
        return cfg_arms;
    endfunction

    function automatic int sat_q88(longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return int'(v);
    endfunction

    function automatic longint unsigned ln_fixed(int unsigned t);
        int unsigned n;
        longint unsigned y;
        longint unsigned frac;
        longint unsigned lg;
        if (t == 0)
        begin
            return 0;
        end
        n = 0;
        while (n < 31 && (t >> (n + 1)) != 0)
        begin
            n++;
        end
        y = ({32'd0, t} << 30) >> n;
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                frac = frac | 64'd1;
            end
        end
        lg = ({32'd0, n} << 16) | frac;
        return (lg * LN2_Q16) >> 16;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void clear_arms();
        for (int i = 0; i < NARMS; i++)
        begin
            est[i] = cfg_init;
            pulls[i] = 0;
            pref[i] = 0;
        end
        total_pulls = 0;
        leader = 0;
        ref_reward = REF_INIT;
    endfunction

    function automatic int unsigned greedy_arm(int unsigned k);
        int mx;
        mx = -2560;
        for (int i = 0; i < k; i++)
        begin
            if (est[i] > mx)
            begin
                mx = est[i];
                leader = i;
            end
        end
        return leader;
    endfunction

    function automatic void pick_arm(int unsigned u, int unsigned rnd,
                                     output int unsigned arm, output bit took_random);
        int unsigned k;
        int mx;
        longint ucb_max;
        longint unsigned ln;
        longint unsigned q;
        longint unsigned s;
        longint unsigned bonus;
        longint ucb;
        k = active_arms();
        took_random = 1'b0;
        case (cfg_mode)
            MODE_EPS:
            begin
                if (u <= cfg_eps)
                begin
                    took_random = 1'b1;
                    arm = rnd % k;
                end
                else
                begin
                    arm = greedy_arm(k);
                end
            end
            MODE_OPT:
            begin
                arm = greedy_arm(k);
            end
            MODE_RC:
            begin
                mx = pref[0];
                leader = 0;
                for (int i = 1; i < k; i++)
                begin
                    if (pref[i] > mx)
                    begin
                        mx = pref[i];
                        leader = i;
                    end
                end
                if (longint'(u) <= longint'(pref[leader]) * 256)
                begin
                    took_random = 1'b1;
                    arm = rnd % k;
                end
                else
                begin
                    arm = leader;
                end
            end
            default:
            begin
                ucb_max = -2560;
                ln = ln_fixed(total_pulls);
                arm = 16;
                for (int i = 0; i < k; i++)
                begin
                    if (arm == 16)
                    begin
                        if (pulls[i] == 0)
                        begin
                            arm = i;
                        end
                        else
                        begin
                            q = ln / pulls[i];
                            s = int_sqrt(q << 16);
                            bonus = (longint'(cfg_weight) * s) >> 16;
                            ucb = longint'(est[i]) + longint'(bonus);
                            if (ucb > ucb_max)
                            begin
                                ucb_max = ucb;
                                leader = i;
                            end
                        end
                    end
                end
                if (arm == 16)
                begin
                    arm = leader;
                end
            end
        endcase
    endfunction

    function automatic void record_reward(int unsigned arm, int r);
        int unsigned cmax;
        longint d;
        cmax = (1 << CNT_BITS) - 1;
        if (arm >= active_arms())
        begin
            return;
        end
        if (pulls[arm] < cmax)
        begin
            pulls[arm]++;
        end
        if (total_pulls < cmax)
        begin
            total_pulls++;
        end
        if (est[arm] == 0)
        begin
            est[arm] = r;
        end
        else
        begin
            est[arm] = int'((longint'(est[arm]) + r) >>> 1);
        end
        if (cfg_mode == MODE_EPS || cfg_mode == MODE_OPT)
        begin
            if (est[arm] > est[leader])
            begin
                leader = arm;
            end
        end
        else if (cfg_mode == MODE_RC)
        begin
            d = longint'(r) - ref_reward;
            pref[leader] = sat_q88(longint'(pref[leader]) + ((longint'(cfg_beta) * d) >>> 16));
            ref_reward = sat_q88(longint'(ref_reward) + ((longint'(cfg_alpha) * d) >>> 16));
        end
    endfunction

    function automatic outcome_t predict_outcome(logic [1:0] op, logic [15:0] u,
                                                 logic [3:0] rnd, logic [3:0] arm,
                                                 logic [15:0] r);
        outcome_t o;
        int unsigned pick;
        bit took;
        o = '0;
        if (op == OP_SELECT)
        begin
            pick_arm(u, rnd, pick, took);
            o.chosen_arm = pick[3:0];
            o.explored = took;
        end
        else if (op == OP_UPDATE)
        begin
            record_reward(arm, $signed(r));
        end
        else if (op == OP_RESTART)
        begin
            clear_arms();
        end
        o.leading_arm = leader[3:0];
        return o;
    endfunction

    always @(negedge clk)
    begin
        stall_cnt++;
        case (stall_cnt[9:8])
            2'd0: rsp.ready <= 1'b1;
            2'd1: rsp.ready <= 1'($urandom_range(0, 1));
            2'd2: rsp.ready <= (stall_cnt[1:0] == 2'd0);
            default: rsp.ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result chosen=%0d explored=%0d leading=%0d",
                         $realtime, rsp.chosen_arm, rsp.explored, rsp.leading_arm);
                failures++;
            end
            else
            begin
                w = pending_outcomes.pop_front();
                if (rsp.chosen_arm !== w.chosen_arm)
                begin
                    $display("%0t: chosen_arm expected %0d actual %0d",
                             $realtime, w.chosen_arm, rsp.chosen_arm);
                    failures++;
                end
                if (rsp.explored !== w.explored)
                begin
                    $display("%0t: explored expected %0d actual %0d",
                             $realtime, w.explored, rsp.explored);
                    failures++;
                end
                if (rsp.leading_arm !== w.leading_arm)
                begin
                    $display("%0t: leading_arm expected %0d actual %0d",
                             $realtime, w.leading_arm, rsp.leading_arm);
                    failures++;
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_item(stim_row_t row);
        outcome_t o;
        req.valid <= 1'b1;
        req.operation <= row.op;
        req.uniform_draw <= row.u;
        req.random_arm <= row.rnd;
        req.pulled_arm <= row.arm;
        req.reward_value <= row.r;
        sender_low = 1'b0;
        forever
        begin
            @(posedge clk);
            if (req.ready)
            begin
                break;
            end
        end
        o = predict_outcome(row.op, row.u, row.rnd, row.arm, row.r);
        pending_outcomes.push_back(row.typed ? row.want : o);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req.valid <= 1'b0;
            sender_low = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic drain();
        if (!sender_low)
        begin
            req.valid <= 1'b0;
            sender_low = 1'b1;
        end
        while (pending_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_POLICY: cfg_mode = val[1:0];
            REG_ARMS:   cfg_arms = val[4:0];
            REG_EPS:    cfg_eps = val;
            REG_INIT:   cfg_init = $signed(val);
            REG_ALPHA:  cfg_alpha = val;
            REG_BETA:   cfg_beta = val;
            default:    cfg_weight = val;
        endcase
        @(negedge clk);
    endtask

    function automatic stim_row_t row_of(logic [1:0] op, logic [15:0] u, logic [3:0] rnd,
                                         logic [3:0] arm, logic [15:0] r, bit typed,
                                         outcome_t want);
        stim_row_t s;
        s.op = op;
        s.u = u;
        s.rnd = rnd;
        s.arm = arm;
        s.r = r;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t s;
        int unsigned pick;
        s.typed = 1'b0;
        s.want = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            s.op = OP_SELECT;
        end
        else if (pick < 92)
        begin
            s.op = OP_UPDATE;
        end
        else if (pick < 97)
        begin
            s.op = OP_RESTART;
        end
        else
        begin
            s.op = OP_UNUSED;
        end
        s.u = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 600)) : 16'($urandom);
        s.rnd = 4'($urandom);
        s.arm = ($urandom_range(0, 6) == 0) ? 4'($urandom)
                                            : 4'($urandom_range(0, active_arms() - 1));
        case ($urandom_range(0, 9))
            0: s.r = 16'h8000;
            1: s.r = 16'h7fff;
            2: s.r = 16'h0000;
            3, 4, 5: s.r = 16'($signed($urandom_range(0, 2047)) - 1024);
            default: s.r = 16'($urandom);
        endcase
        return s;
    endfunction

    stim_row_t  directed [$];
    logic [15:0] phase_cfg [PHASES][7];

    initial
    begin
        req.valid = 1'b0;
        req.operation = OP_SELECT;
        req.uniform_draw = '0;
        req.random_arm = '0;
        req.pulled_arm = '0;
        req.reward_value = '0;
        rsp.ready = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_POLICY;
        wr_data = '0;
        rst_n = 1'b0;
        failures = 0;
        cycles = 0;
        stall_cnt = 0;
        sender_low = 1'b1;
        burst_left = $urandom_range(1, 20);

        cfg_mode = MODE_EPS;
        cfg_arms = 5'd16;
        cfg_eps = 6554;
        cfg_init = 0;
        cfg_alpha = 6554;
        cfg_beta = 6554;
        cfg_weight = 512;
        clear_arms();

        phase_cfg = '{
            '{MODE_EPS, 16'd16, 16'd6554, 16'd0, 16'd6554, 16'd6554, 16'd512},
            '{MODE_OPT, 16'd5, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0},
            '{MODE_RC, 16'd16, 16'd6554, 16'd0, 16'd6554, 16'd6554, 16'd512},
            '{MODE_UCB, 16'd16, 16'd0, 16'd0, 16'd0, 16'd0, 16'd512},
            '{MODE_UCB, 16'd3, 16'hffff, 16'h8000, 16'hffff, 16'hffff, 16'hffff},
            '{MODE_RC, 16'd0, 16'hffff, 16'h8000, 16'hffff, 16'hffff, 16'd0},
            '{MODE_EPS, 16'd31, 16'hffff, 16'd100, 16'd1000, 16'd40000, 16'd1},
            '{MODE_OPT, 16'd1, 16'd30000, 16'hf600, 16'd0, 16'hffff, 16'hffff},
            '{MODE_UCB, 16'd8, 16'd1, 16'hff9c, 16'd5, 16'd5, 16'd300},
            '{MODE_RC, 16'd7, 16'd0, 16'h7fff, 16'hffff, 16'd0, 16'hffff}
        };

        directed.push_back(row_of(OP_SELECT, 16'd0, 4'd5, 4'd0, 16'd0, 1, '{4'd5, 1'b1, 4'd0}));
        directed.push_back(row_of(OP_SELECT, 16'hffff, 4'd15, 4'd0, 16'd0, 1, '{4'd0, 1'b0, 4'd0}));
        directed.push_back(row_of(OP_SELECT, 16'd6554, 4'd9, 4'd0, 16'd0, 1, '{4'd9, 1'b1, 4'd0}));
        directed.push_back(row_of(OP_SELECT, 16'd6555, 4'd9, 4'd0, 16'd0, 1, '{4'd0, 1'b0, 4'd0}));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd3, 16'h7fff, 1, '{4'd0, 1'b0, 4'd3}));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd3, 16'h8000, 0, '0));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd15, 16'd100, 0, '0));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd0, 16'h8000, 0, '0));
        directed.push_back(row_of(OP_SELECT, 16'hffff, 4'd0, 4'd0, 16'd0, 0, '0));
        directed.push_back(row_of(OP_UNUSED, 16'hffff, 4'hf, 4'hf, 16'hffff, 0, '0));
        directed.push_back(row_of(OP_RESTART, 16'd0, 4'd0, 4'd0, 16'd0, 1, '{4'd0, 1'b0, 4'd0}));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd7, 16'd0, 0, '0));
        directed.push_back(row_of(OP_UPDATE, 16'd0, 4'd0, 4'd7, 16'hffff, 0, '0));
        directed.push_back(row_of(OP_SELECT, 16'hffff, 4'd3, 4'd0, 16'd0, 0, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            for (int g = 0; g < 7; g++)
            begin
                write_reg(3'(g), phase_cfg[p][g]);
            end
            wr_en <= 1'b0;
            @(negedge clk);
            send_item(row_of(OP_RESTART, 16'($urandom), 4'($urandom), 4'($urandom),
                             16'($urandom), 0, '0));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off mid-phase until the block has caught up
                if (p == 4 && n == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                send_item(random_row());
            end
        end

        drain();
        repeat (1000) @(posedge clk);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- bandit_arm_selector_core.f -----
hw/rtl/bas_pkg.sv
hw/rtl/bas_interfaces.sv
hw/rtl/bas_mem.sv
hw/rtl/bas_ucb.sv
hw/rtl/bandit_arm_selector_core.sv
tb/bandit_arm_selector_core_tb.sv
